/* design/bdhr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Button debounce package
// Shared widths, register indexes and beat types for the debounce block.
// ----------------------------------------------------------------------------
package bdhr_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG       = 3'd4;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_W-1:0] HOLD_START_RST = 16'd500;
    localparam logic [CFG_W-1:0] REPEAT_RST     = 16'd150;
    localparam logic [CFG_W-1:0] ACCEL_RST      = 16'd1200;
    localparam logic [CFG_W-1:0] LONG_RST       = 16'd1000;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_interval;
        logic [CFG_W-1:0] hold_start;
        logic [CFG_W-1:0] repeat_period;
        logic [CFG_W-1:0] accelerate_after;
        logic [CFG_W-1:0] long_press_time;
    } cfg_t;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] raw_levels;
        logic [NUM_BUTTONS-1:0] ack_press_mask;
        logic [NUM_BUTTONS-1:0] poll_hold_mask;
        logic [NUM_BUTTONS-1:0] poll_long_mask;
    } item_t;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] down_mask;
        logic [NUM_BUTTONS-1:0] press_taken_mask;
        logic [NUM_BUTTONS-1:0] repeat_fire_mask;
        logic [NUM_BUTTONS-1:0] long_fire_mask;
    } result_t;

    // Per-button query inputs for one tick.
    typedef struct packed {
        logic sample;
        logic level;
        logic ack;
        logic poll_hold;
        logic poll_long;
    } btn_in_t;

    // Per-button flags for one tick.
    typedef struct packed {
        logic down;
        logic taken;
        logic fire_repeat;
        logic fire_long;
    } btn_out_t;

endpackage
`default_nettype wire

/* design/bdhr_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// Five 16-bit timing registers written through a plain write port.
// ----------------------------------------------------------------------------
module bdhr_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [bdhr_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [bdhr_pkg::CFG_W-1:0]     wr_data,
    output bdhr_pkg::cfg_t                     cfg
);

    bdhr_pkg::cfg_t cfg_reg;
    bdhr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                bdhr_pkg::CFG_DEBOUNCE:   cfg_next.debounce_interval = wr_data;
                bdhr_pkg::CFG_HOLD_START: cfg_next.hold_start        = wr_data;
                bdhr_pkg::CFG_REPEAT:     cfg_next.repeat_period     = wr_data;
                bdhr_pkg::CFG_ACCEL:      cfg_next.accelerate_after  = wr_data;
                bdhr_pkg::CFG_LONG:       cfg_next.long_press_time   = wr_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_interval <= bdhr_pkg::DEBOUNCE_RST;
            cfg_reg.hold_start        <= bdhr_pkg::HOLD_START_RST;
            cfg_reg.repeat_period     <= bdhr_pkg::REPEAT_RST;
            cfg_reg.accelerate_after  <= bdhr_pkg::ACCEL_RST;
            cfg_reg.long_press_time   <= bdhr_pkg::LONG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

/* design/bdhr_button.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Per-button state
// Debounced level, pending press, hold flag and timestamps of one button,
// with the sample step and the three queries of one tick.
// ----------------------------------------------------------------------------
module bdhr_button (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic [bdhr_pkg::TIME_W-1:0] now,
    input  wire bdhr_pkg::cfg_t             cfg,
    input  wire bdhr_pkg::btn_in_t          btn_in,
    output bdhr_pkg::btn_out_t              btn_out
);

    logic                       level_reg,      level_next;
    logic                       pending_reg,    pending_next;
    logic                       hold_reg,       hold_next;
    logic [bdhr_pkg::TIME_W-1:0] press_time_reg, press_time_next;
    logic [bdhr_pkg::TIME_W-1:0] repeat_time_reg, repeat_time_next;

    logic                       falling;
    logic                       pend_s;
    logic                       hold_s;
    logic [bdhr_pkg::TIME_W-1:0] age_old;
    logic [bdhr_pkg::TIME_W-1:0] age;
    logic [bdhr_pkg::TIME_W-1:0] since_repeat;
    logic [bdhr_pkg::CFG_W-1:0]  period;
    logic                       taken;
    logic                       pend_a;
    logic                       fire_repeat;
    logic                       fire_long;

    always_comb
    begin
        // Sample step. A falling edge stamps the press with the current time,
        // so the age seen by the hold check is zero on that tick.
        falling         = btn_in.sample && !btn_in.level && level_reg;
        age_old         = now - press_time_reg;
        pend_s          = pending_reg;
        hold_s          = hold_reg;
        level_next      = level_reg;
        press_time_next = press_time_reg;
        if (btn_in.sample)
        begin
            level_next = btn_in.level;
            if (falling)
            begin
                pend_s          = 1'b1;
                hold_s          = 1'b0;
                press_time_next = now;
            end
            else if (btn_in.level)
            begin
                pend_s = 1'b0;
                hold_s = 1'b0;
            end
        end
        age = falling ? '0 : age_old;
        if (btn_in.sample && !btn_in.level
            && (age > {{(bdhr_pkg::TIME_W-bdhr_pkg::CFG_W){1'b0}}, cfg.hold_start}))
        begin
            hold_s = 1'b1;
        end

        // Press acknowledge.
        taken  = btn_in.ack && pend_s;
        pend_a = pend_s && !taken;

        // Hold repeat; the period halves once the press is old enough.
        period = (age > {{(bdhr_pkg::TIME_W-bdhr_pkg::CFG_W){1'b0}}, cfg.accelerate_after})
               ? {1'b0, cfg.repeat_period[bdhr_pkg::CFG_W-1:1]}
               : cfg.repeat_period;
        since_repeat     = now - repeat_time_reg;
        fire_repeat      = btn_in.poll_hold && hold_s
                         && (since_repeat > {{(bdhr_pkg::TIME_W-bdhr_pkg::CFG_W){1'b0}}, period});
        repeat_time_next = fire_repeat ? now : repeat_time_reg;

        // Long press consumes the pending press.
        fire_long    = btn_in.poll_long && pend_a
                     && (age > {{(bdhr_pkg::TIME_W-bdhr_pkg::CFG_W){1'b0}},
                                cfg.long_press_time});
        pending_next = pend_a && !fire_long;
        hold_next    = hold_s;

        btn_out.down        = !level_next;
        btn_out.taken       = taken;
        btn_out.fire_repeat = fire_repeat;
        btn_out.fire_long   = fire_long;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= 1'b1;
            pending_reg     <= 1'b0;
            hold_reg        <= 1'b0;
            press_time_reg  <= '0;
            repeat_time_reg <= '0;
        end
        else if (step)
        begin
            level_reg       <= level_next;
            pending_reg     <= pending_next;
            hold_reg        <= hold_next;
            press_time_reg  <= press_time_next;
            repeat_time_reg <= repeat_time_next;
        end
    end

endmodule
`default_nettype wire

/* design/button_debounce_hold_repeat.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Button debounce with hold repeat and long press
// Millisecond-tick debounce of active-low buttons with press, repeat and
// long-press queries.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+---------------------------
//  item     | item_valid / item_stall   | item   (bdhr_pkg::item_t)
//  result   | result_valid/result_stall | result (bdhr_pkg::result_t)
//  config   | wr_en                     | wr_index, wr_data
//
// One tick beat is taken per cycle while item_stall is low; it is registered in the
// input register, then in the result register once that register can accept it.
// The tick logic is a few 32-bit subtract-and-compare paths per button.
// Reset puts the timing registers to their defaults and all buttons to released.
// While the result register is stalled, one further beat is held in the input
// register, and item_stall rises only when both are full.
// ----------------------------------------------------------------------------
module button_debounce_hold_repeat (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output      logic                          item_stall,
    input  wire bdhr_pkg::item_t               item,
    output      logic                          result_valid,
    input  wire logic                          result_stall,
    output bdhr_pkg::result_t                  result,
    input  wire logic                          wr_en,
    input  wire logic [bdhr_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [bdhr_pkg::CFG_W-1:0]     wr_data
);

    bdhr_pkg::cfg_t    cfg;
    bdhr_pkg::item_t   item_reg;
    bdhr_pkg::result_t result_reg, result_next;
    logic              item_valid_reg, item_valid_next;
    logic              result_valid_reg, result_valid_next;
    logic [bdhr_pkg::TIME_W-1:0] time_reg, time_next;
    logic [bdhr_pkg::TIME_W-1:0] sample_time_reg, sample_time_next;
    logic              take;
    logic              step;
    logic              sample;

    bdhr_pkg::btn_in_t  btn_in  [bdhr_pkg::NUM_BUTTONS];
    bdhr_pkg::btn_out_t btn_out [bdhr_pkg::NUM_BUTTONS];

    bdhr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    assign step       = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !step;
    assign take       = item_valid && !item_stall;

    assign item_valid_next   = take || (item_valid_reg && !step);
    assign result_valid_next = step || (result_valid_reg && result_stall);

    always_comb
    begin
        time_next        = time_reg + 1'b1;
        sample           = ((time_next - sample_time_reg)
                           >= {{(bdhr_pkg::TIME_W-bdhr_pkg::CFG_W){1'b0}},
                               cfg.debounce_interval});
        sample_time_next = sample ? time_next : sample_time_reg;
    end

    for (genvar i = 0; i < bdhr_pkg::NUM_BUTTONS; i++)
    begin : g_btn
        assign btn_in[i].sample    = sample;
        assign btn_in[i].level     = item_reg.raw_levels[i];
        assign btn_in[i].ack       = item_reg.ack_press_mask[i];
        assign btn_in[i].poll_hold = item_reg.poll_hold_mask[i];
        assign btn_in[i].poll_long = item_reg.poll_long_mask[i];

        bdhr_button u_button (
            .clk     (clk),
            .rst_n   (rst_n),
            .step    (step),
            .now     (time_next),
            .cfg     (cfg),
            .btn_in  (btn_in[i]),
            .btn_out (btn_out[i])
        );

        assign result_next.down_mask[i]        = btn_out[i].down;
        assign result_next.press_taken_mask[i] = btn_out[i].taken;
        assign result_next.repeat_fire_mask[i] = btn_out[i].fire_repeat;
        assign result_next.long_fire_mask[i]   = btn_out[i].fire_long;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            time_reg         <= '0;
            sample_time_reg  <= '0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
            if (step)
            begin
                time_reg        <= time_next;
                sample_time_reg <= sample_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

/* test/button_debounce_hold_repeat_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the button debounce block with hold repeat and long press
// Drives millisecond tick beats through the item channel and checks every
// result beat against a cycle-free model of the debounce, press, repeat and
// long-press logic. The timing registers are reloaded between phases, with
// random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module button_debounce_hold_repeat_tb;

    localparam int QUIET_LIMIT = 3000;
    localparam int SQUEEZE_CYCLES = 200;

    // Tracks the button state per tick and holds the results still to come.
    class debounce_scoreboard;
        bdhr_pkg::cfg_t    regs;
        bit [31:0]         now_ms;
        bit [31:0]         sampled_at;
        bit [2:0]          level_now;
        bit [2:0]          level_before;
        bit [2:0]          pending;
        bit [2:0]          holding;
        bit [31:0]         pressed_at[bdhr_pkg::NUM_BUTTONS];
        bit [31:0]         repeated_at[bdhr_pkg::NUM_BUTTONS];
        bdhr_pkg::result_t expected_masks[$];
        int                errors;

        function new();
            regs.debounce_interval = bdhr_pkg::DEBOUNCE_RST;
            regs.hold_start        = bdhr_pkg::HOLD_START_RST;
            regs.repeat_period     = bdhr_pkg::REPEAT_RST;
            regs.accelerate_after  = bdhr_pkg::ACCEL_RST;
            regs.long_press_time   = bdhr_pkg::LONG_RST;
            now_ms       = '0;
            sampled_at   = '0;
            level_now    = '1;
            level_before = '1;
            pending      = '0;
            holding      = '0;
            errors       = 0;
            for (int b = 0; b < bdhr_pkg::NUM_BUTTONS; b++)
            begin
                pressed_at[b]  = '0;
                repeated_at[b] = '0;
            end
        endfunction

        function void apply_write(logic [bdhr_pkg::CFG_IDX_W-1:0] idx,
                                  logic [bdhr_pkg::CFG_W-1:0] val);
            case (idx)
                bdhr_pkg::CFG_DEBOUNCE:   regs.debounce_interval = val;
                bdhr_pkg::CFG_HOLD_START: regs.hold_start        = val;
                bdhr_pkg::CFG_REPEAT:     regs.repeat_period     = val;
                bdhr_pkg::CFG_ACCEL:      regs.accelerate_after  = val;
                bdhr_pkg::CFG_LONG:       regs.long_press_time   = val;
                default:                  ;
            endcase
        endfunction

        function int outstanding();
            return expected_masks.size();
        endfunction

        function void note_tick(bdhr_pkg::item_t t);
            bdhr_pkg::result_t r;
            bit [31:0]         period;
            r = '0;
            now_ms = now_ms + 32'd1;
            if (now_ms - sampled_at >= {16'd0, regs.debounce_interval})
            begin
                sampled_at = now_ms;
                for (int b = 0; b < bdhr_pkg::NUM_BUTTONS; b++)
                begin
                    level_before[b] = level_now[b];
                    level_now[b]    = t.raw_levels[b];
                    if (!level_now[b] && level_before[b])
                    begin
                        pending[b]    = 1'b1;
                        pressed_at[b] = now_ms;
                        holding[b]    = 1'b0;
                    end
                    else if (level_now[b])
                    begin
                        pending[b] = 1'b0;
                        holding[b] = 1'b0;
                    end
                    if (!level_now[b] && (now_ms - pressed_at[b]) > {16'd0, regs.hold_start})
                        holding[b] = 1'b1;
                end
            end
            // Acknowledge runs first, so a press it consumes cannot also go long.
            for (int b = 0; b < bdhr_pkg::NUM_BUTTONS; b++)
            begin
                if (t.ack_press_mask[b] && pending[b])
                begin
                    pending[b] = 1'b0;
                    r.press_taken_mask[b] = 1'b1;
                end
                if (t.poll_hold_mask[b] && holding[b])
                begin
                    period = {16'd0, regs.repeat_period};
                    if ((now_ms - pressed_at[b]) > {16'd0, regs.accelerate_after})
                        period = period >> 1;
                    if ((now_ms - repeated_at[b]) > period)
                    begin
                        repeated_at[b] = now_ms;
                        r.repeat_fire_mask[b] = 1'b1;
                    end
                end
                if (t.poll_long_mask[b] && pending[b]
                    && (now_ms - pressed_at[b]) > {16'd0, regs.long_press_time})
                begin
                    pending[b] = 1'b0;
                    r.long_fire_mask[b] = 1'b1;
                end
                r.down_mask[b] = !level_now[b];
            end
            expected_masks.push_back(r);
        endfunction

        function void check_result(bdhr_pkg::result_t got);
            bdhr_pkg::result_t want;
            if (expected_masks.size() == 0)
            begin
                $error("result beat %h arrived with no tick outstanding", got);
                errors++;
                return;
            end
            want = expected_masks.pop_front();
            if (got.down_mask !== want.down_mask)
            begin
                $error("down_mask: expected %h, actual %h", want.down_mask, got.down_mask);
                errors++;
            end
            if (got.press_taken_mask !== want.press_taken_mask)
            begin
                $error("press_taken_mask: expected %h, actual %h",
                       want.press_taken_mask, got.press_taken_mask);
                errors++;
            end
            if (got.repeat_fire_mask !== want.repeat_fire_mask)
            begin
                $error("repeat_fire_mask: expected %h, actual %h",
                       want.repeat_fire_mask, got.repeat_fire_mask);
                errors++;
            end
            if (got.long_fire_mask !== want.long_fire_mask)
            begin
                $error("long_fire_mask: expected %h, actual %h",
                       want.long_fire_mask, got.long_fire_mask);
                errors++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           item_valid = 1'b0;
    logic                           item_stall;
    bdhr_pkg::item_t                item = '0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    bdhr_pkg::result_t              result;
    logic                           wr_en = 1'b0;
    logic [bdhr_pkg::CFG_IDX_W-1:0] wr_index = '0;
    logic [bdhr_pkg::CFG_W-1:0]     wr_data = '0;

    debounce_scoreboard sb = new();

    bit       calm = 1'b0;
    bit       squeeze_phase = 1'b0;
    bit       squeeze_req = 1'b0;
    bit [2:0] finger = 3'b111;
    int       toggle_odds = 8;

    button_debounce_hold_repeat u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Holds the tick beat until it is taken; valid is left high for the next one.
    task automatic send_tick(input bdhr_pkg::item_t t);
        item       <= t;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_tick(t);
    endtask

    task automatic poke(input logic [2:0] raw, input logic [2:0] ack,
                        input logic [2:0] hold, input logic [2:0] lng);
        send_tick({raw, ack, hold, lng});
    endtask

    // Loads all five timing registers and scribbles on the unused indexes.
    task automatic load_settings(input bdhr_pkg::cfg_t s);
        logic [bdhr_pkg::CFG_W-1:0] v;
        wr_en <= 1'b1;
        for (int k = 0; k < 8; k++)
        begin
            case (k[bdhr_pkg::CFG_IDX_W-1:0])
                bdhr_pkg::CFG_DEBOUNCE:   v = s.debounce_interval;
                bdhr_pkg::CFG_HOLD_START: v = s.hold_start;
                bdhr_pkg::CFG_REPEAT:     v = s.repeat_period;
                bdhr_pkg::CFG_ACCEL:      v = s.accelerate_after;
                bdhr_pkg::CFG_LONG:       v = s.long_press_time;
                default:                  v = bdhr_pkg::CFG_W'($urandom);
            endcase
            wr_index <= k[bdhr_pkg::CFG_IDX_W-1:0];
            wr_data  <= v;
            @(posedge clk);
            sb.apply_write(k[bdhr_pkg::CFG_IDX_W-1:0], v);
        end
        wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (sb.outstanding() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    function automatic bdhr_pkg::item_t next_item();
        bdhr_pkg::item_t t;
        for (int b = 0; b < bdhr_pkg::NUM_BUTTONS; b++)
            if ($urandom_range(0, toggle_odds - 1) == 0)
                finger[b] = ~finger[b];
        // Mostly sustained presses; now and then a bouncing, random level.
        t.raw_levels     = ($urandom_range(0, 9) == 0) ? 3'($urandom) : finger;
        t.ack_press_mask = 3'($urandom & $urandom);
        t.poll_hold_mask = 3'($urandom);
        t.poll_long_mask = 3'($urandom);
        return t;
    endfunction

    task automatic run_phase(input bdhr_pkg::cfg_t s, input int count);
        load_settings(s);
        toggle_odds = $urandom_range(3, 40);
        for (int n = 0; n < count; n++)
        begin
            if (!calm && !squeeze_phase && $urandom_range(0, 7) == 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            send_tick(next_item());
        end
        item_valid <= 1'b0;
        drain();
    endtask

    function automatic bdhr_pkg::cfg_t small_settings();
        bdhr_pkg::cfg_t s;
        s.debounce_interval = bdhr_pkg::CFG_W'($urandom_range(0, 4));
        s.hold_start        = bdhr_pkg::CFG_W'($urandom_range(0, 30));
        s.repeat_period     = bdhr_pkg::CFG_W'($urandom_range(0, 12));
        s.accelerate_after  = bdhr_pkg::CFG_W'($urandom_range(0, 60));
        s.long_press_time   = bdhr_pkg::CFG_W'($urandom_range(0, 50));
        return s;
    endfunction

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
                sb.check_result(result);
            if (squeeze_req)
            begin
                burst = SQUEEZE_CYCLES;
                squeeze_req = 1'b0;
            end
            else if (burst == 0 && !calm && $urandom_range(0, 5) == 0)
                burst = $urandom_range(1, 19);
            if (burst > 0)
            begin
                result_stall <= 1'b1;
                burst--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Ends the run if no beat moves on either channel for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        bdhr_pkg::cfg_t s;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed ticks with short timings so every query fires quickly.
        s.debounce_interval = 16'd0;
        s.hold_start        = 16'd2;
        s.repeat_period     = 16'd1;
        s.accelerate_after  = 16'd5;
        s.long_press_time   = 16'd3;
        load_settings(s);
        poke(3'd7, 3'd0, 3'd0, 3'd0);
        poke(3'd0, 3'd0, 3'd0, 3'd0);
        poke(3'd0, 3'd0, 3'd7, 3'd7);
        poke(3'd0, 3'd0, 3'd7, 3'd7);
        poke(3'd0, 3'd0, 3'd7, 3'd7);
        poke(3'd0, 3'd0, 3'd7, 3'd7);
        poke(3'd0, 3'd7, 3'd7, 3'd7);
        poke(3'd0, 3'd0, 3'd7, 3'd0);
        poke(3'd0, 3'd0, 3'd7, 3'd0);
        poke(3'd7, 3'd7, 3'd7, 3'd7);
        poke(3'd0, 3'd0, 3'd0, 3'd0);
        poke(3'd0, 3'd0, 3'd0, 3'd0);
        poke(3'd0, 3'd0, 3'd0, 3'd0);
        poke(3'd0, 3'd0, 3'd0, 3'd0);
        // A press acknowledged in the same tick that it would go long.
        poke(3'd0, 3'd7, 3'd0, 3'd7);
        poke(3'd5, 3'd0, 3'd7, 3'd0);
        poke(3'd2, 3'd2, 3'd2, 3'd2);
        poke(3'd7, 3'd7, 3'd7, 3'd7);
        poke(3'd0, 3'd7, 3'd7, 3'd7);
        poke(3'd7, 3'd0, 3'd0, 3'd0);
        item_valid <= 1'b0;
        drain();

        s = '0;
        run_phase(s, 40);
        s = '1;
        run_phase(s, 30);
        s.debounce_interval = bdhr_pkg::DEBOUNCE_RST;
        s.hold_start        = bdhr_pkg::HOLD_START_RST;
        s.repeat_period     = bdhr_pkg::REPEAT_RST;
        s.accelerate_after  = bdhr_pkg::ACCEL_RST;
        s.long_press_time   = bdhr_pkg::LONG_RST;
        run_phase(s, 60);
        for (int p = 0; p < 9; p++)
        begin
            if (p == 4)
            begin
                squeeze_phase = 1'b1;
                squeeze_req   = 1'b1;
            end
            if (p == 8)
                calm = 1'b1;
            run_phase(small_settings(), 90);
            squeeze_phase = 1'b0;
        end

        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* button_debounce_hold_repeat.f */
design/bdhr_pkg.sv
design/bdhr_cfg.sv
design/bdhr_button.sv
design/button_debounce_hold_repeat.sv
test/button_debounce_hold_repeat_tb.sv
